>>> rtl/bmg_pkg.sv
// Shared constants, latencies and types of the Box-Muller Gaussian unit.
package bmg_pkg;

   localparam int UNIFORM_BITS_DEF  = 32;
   localparam int OUT_FRAC_BITS_DEF = 19;

   // ln 2 in Q0.28 and 2*pi in Q3.29, both truncated.
   localparam logic [27:0] LN2_Q28    = 28'd186065279;
   localparam logic [31:0] TWO_PI_Q29 = 32'd3373259426;
   localparam logic [32:0] Q32_ONE    = 33'h1_0000_0000;

   localparam int LOG_STEPS = 30;
   localparam int ROOT_BITS = 32;
   localparam int SIN_TERMS = 5;
   localparam int COS_TERMS = 6;

   // Horner divisors of the truncated Taylor series, innermost term first.
   localparam int SIN_DIV [SIN_TERMS] = '{110, 72, 42, 20, 6};
   localparam int COS_DIV [COS_TERMS] = '{132, 90, 56, 30, 12, 2};

   // Register stages of each unit.
   localparam int NEGLOG_LAT = LOG_STEPS + 4;
   localparam int SQRT_LAT   = ROOT_BITS;
   localparam int TRIG_LAT   = 2 * COS_TERMS + 3;

   typedef struct packed {
      logic [32:0] cos_mag;
      logic [32:0] sin_mag;
      logic        cos_neg;
      logic        sin_neg;
   } trig_type;

endpackage

>>> rtl/bmg_channels_if.sv
// Valid/ready channel interfaces for the uniform inputs and the normal samples.
interface bmg_req_if import bmg_pkg::*; #(
   parameter int UNIFORM_BITS = UNIFORM_BITS_DEF
);
   logic                    valid;
   logic                    ready;
   logic [UNIFORM_BITS-1:0] uniform_radius;
   logic [UNIFORM_BITS-1:0] uniform_angle;

   modport source (output valid, output uniform_radius, output uniform_angle, input ready);
   modport sink (input valid, input uniform_radius, input uniform_angle, output ready);
endinterface

interface bmg_rsp_if import bmg_pkg::*; #(
   parameter int OUT_FRAC_BITS = OUT_FRAC_BITS_DEF
);
   logic                        valid;
   logic                        ready;
   logic signed [OUT_FRAC_BITS+3:0] normal_cos;
   logic signed [OUT_FRAC_BITS+3:0] normal_sin;

   modport source (output valid, output normal_cos, output normal_sin, input ready);
   modport sink (input valid, input normal_cos, input normal_sin, output ready);
endinterface

>>> rtl/bmg_neglog.sv
// Pipelined -2 ln(u1) in Q7.30 by normalization and repeated squaring, shifted for the root.
module bmg_neglog import bmg_pkg::*; #(
   parameter int UNIFORM_BITS = UNIFORM_BITS_DEF
) (
   input  logic                    clock,
   input  logic                    en,
   input  logic [UNIFORM_BITS-1:0] x_in,
   output logic [63:0]             v_out
);
   localparam int PW   = $clog2(UNIFORM_BITS);
   localparam int EW   = $clog2(UNIFORM_BITS + 1);
   localparam int LQ_W = EW + LOG_STEPS;

   logic [UNIFORM_BITS-1:0] x0_ff;
   logic [PW-1:0]           pos0_ff;
   logic [UNIFORM_BITS-1:0] xz;
   logic [PW-1:0]           pos_in;
   logic [UNIFORM_BITS-1:0] xn;
   logic [31:0]             mn_in;
   logic [31:0]             mn_ff;
   logic [EW-1:0]           e0_ff;
   logic [31:0]             m_ff    [LOG_STEPS-1];
   logic [LOG_STEPS-1:0]    frac_ff [LOG_STEPS];
   logic [EW-1:0]           e_ff    [LOG_STEPS];
   logic [LQ_W-1:0]         lq_ff;
   logic [LQ_W+27:0]        w_prod;
   logic [63:0]             v_ff;

   // A zero input is taken as the smallest nonzero value.
   always_comb begin
      xz = (x_in == '0) ? UNIFORM_BITS'(1) : x_in;
      pos_in = '0;
      for (int i = 0; i < UNIFORM_BITS; i++) begin
         if (xz[i]) pos_in = PW'(i);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x0_ff   <= xz;
         pos0_ff <= pos_in;
      end
   end

   assign xn = x0_ff << (PW'(UNIFORM_BITS - 1) - pos0_ff);

   if (UNIFORM_BITS >= 32) begin : g_norm_wide
      assign mn_in = xn[UNIFORM_BITS-1 -: 32];
   end else begin : g_norm_narrow
      assign mn_in = {xn, {(32 - UNIFORM_BITS){1'b0}}};
   end

   always_ff @(posedge clock) begin
      if (en) begin
         mn_ff <= mn_in;
         e0_ff <= EW'(UNIFORM_BITS) - EW'(pos0_ff);
      end
   end

   // Each step squares the Q1.31 mantissa; an overflow past 2.0 yields the next fraction bit.
   for (genvar k = 0; k < LOG_STEPS; k++) begin : g_square
      logic [31:0]          m_src;
      logic [LOG_STEPS-1:0] frac_src;
      logic [EW-1:0]        e_src;
      logic [63:0]          sq;
      logic [32:0]          s33;

      if (k == 0) begin : g_first
         assign m_src    = mn_ff;
         assign frac_src = '0;
         assign e_src    = e0_ff;
      end else begin : g_next
         assign m_src    = m_ff[k-1];
         assign frac_src = frac_ff[k-1];
         assign e_src    = e_ff[k-1];
      end

      assign sq  = 64'(m_src) * 64'(m_src);
      assign s33 = sq[63:31];

      always_ff @(posedge clock) begin
         if (en) begin
            frac_ff[k] <= {frac_src[LOG_STEPS-2:0], s33[32]};
            e_ff[k]    <= e_src;
         end
      end

      if (k < LOG_STEPS - 1) begin : g_keep
         always_ff @(posedge clock) begin
            if (en) begin
               m_ff[k] <= s33[32] ? s33[32:1] : s33[31:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         lq_ff <= {e_ff[LOG_STEPS-1], {LOG_STEPS{1'b0}}}
                  - LQ_W'(frac_ff[LOG_STEPS-1]);
      end
   end

   assign w_prod = (LQ_W + 28)'(lq_ff) * (LQ_W + 28)'(LN2_Q28);

   always_ff @(posedge clock) begin
      if (en) begin
         v_ff <= 64'({w_prod[LQ_W+27:27], 26'b0});
      end
   end

   assign v_out = v_ff;

endmodule

>>> rtl/bmg_sqrt.sv
// Pipelined integer square root, one root bit per stage.
module bmg_sqrt import bmg_pkg::*; (
   input  logic                 clock,
   input  logic                 en,
   input  logic [63:0]          v_in,
   output logic [ROOT_BITS-1:0] root_out
);
   logic [ROOT_BITS+1:0] rem_ff  [ROOT_BITS-1];
   logic [ROOT_BITS-1:0] root_ff [ROOT_BITS];
   logic [63:0]          v_ff    [ROOT_BITS-1];

   for (genvar k = 0; k < ROOT_BITS; k++) begin : g_stage
      logic [ROOT_BITS+1:0] rem_src;
      logic [ROOT_BITS-1:0] root_src;
      logic [63:0]          v_src;
      logic [ROOT_BITS+1:0] rem_sh;
      logic [ROOT_BITS+1:0] trial;
      logic                 fits;

      if (k == 0) begin : g_first
         assign rem_src  = '0;
         assign root_src = '0;
         assign v_src    = v_in;
      end else begin : g_next
         assign rem_src  = rem_ff[k-1];
         assign root_src = root_ff[k-1];
         assign v_src    = v_ff[k-1];
      end

      // Bring down the next bit pair and try the root with a one appended.
      assign rem_sh = {rem_src[ROOT_BITS-1:0], v_src[63:62]};
      assign trial  = {root_src, 2'b01};
      assign fits   = (rem_sh >= trial);

      always_ff @(posedge clock) begin
         if (en) begin
            root_ff[k] <= {root_src[ROOT_BITS-2:0], fits};
         end
      end

      if (k < ROOT_BITS - 1) begin : g_carry
         always_ff @(posedge clock) begin
            if (en) begin
               rem_ff[k] <= fits ? rem_sh - trial : rem_sh;
               v_ff[k]   <= {v_src[61:0], 2'b00};
            end
         end
      end
   end

   assign root_out = root_ff[ROOT_BITS-1];

endmodule

>>> rtl/bmg_sincos.sv
// Pipelined sine and cosine of a Q0.32 turn: octant fold, Horner series, quadrant signs.
module bmg_sincos import bmg_pkg::*; #(
   parameter int UNIFORM_BITS = UNIFORM_BITS_DEF
) (
   input  logic                    clock,
   input  logic                    en,
   input  logic [UNIFORM_BITS-1:0] angle_in,
   output trig_type                trig_out
);
   localparam int POS = 2 * COS_TERMS + 1;

   typedef struct packed {
      logic [1:0] quad;
      logic       fold;
   } angle_meta_type;

   logic [31:0]    turn;
   logic [29:0]    resid;
   logic [29:0]    rr;
   logic [61:0]    t_prod;
   logic [31:0]    t1_ff;
   angle_meta_type meta1_ff;
   logic [63:0]    t2_prod;

   logic [31:0]    t2_p   [2*COS_TERMS-1];
   logic [31:0]    t_p    [2*COS_TERMS];
   angle_meta_type meta_p [POS];

   logic [31:0]    cx_ff [COS_TERMS];
   logic [32:0]    ca_ff [COS_TERMS];
   logic [31:0]    sx_ff [SIN_TERMS];
   logic [32:0]    sa_ff [SIN_TERMS];
   logic [64:0]    s_prod;
   logic [31:0]    s_ff;
   logic           swap;
   trig_type       trig_ff;

   if (UNIFORM_BITS >= 32) begin : g_turn_wide
      assign turn = angle_in[UNIFORM_BITS-1 -: 32];
   end else begin : g_turn_narrow
      assign turn = {angle_in, {(32 - UNIFORM_BITS){1'b0}}};
   end

   // The upper half of each quadrant is mirrored onto the lower octant.
   assign resid  = turn[29:0];
   assign rr     = resid[29] ? 30'(31'h4000_0000 - 31'(resid)) : resid;
   assign t_prod = 62'(rr) * 62'(TWO_PI_Q29);

   always_ff @(posedge clock) begin
      if (en) begin
         t1_ff         <= t_prod[60:29];
         meta1_ff.quad <= turn[31:30];
         meta1_ff.fold <= resid[29];
      end
   end

   assign t2_prod = 64'(t1_ff) * 64'(t1_ff);

   always_ff @(posedge clock) begin
      if (en) begin
         t2_p[0]   <= t2_prod[63:32];
         t_p[0]    <= t1_ff;
         meta_p[0] <= meta1_ff;
      end
   end

   for (genvar j = 1; j < POS; j++) begin : g_carry
      always_ff @(posedge clock) begin
         if (en) begin
            meta_p[j] <= meta_p[j-1];
         end
      end

      if (j < 2 * COS_TERMS - 1) begin : g_t2
         always_ff @(posedge clock) begin
            if (en) begin
               t2_p[j] <= t2_p[j-1];
            end
         end
      end

      if (j < 2 * COS_TERMS) begin : g_t
         always_ff @(posedge clock) begin
            if (en) begin
               t_p[j] <= t_p[j-1];
            end
         end
      end
   end

   // Each Horner step is a multiply stage followed by a reciprocal-multiply divide stage.
   for (genvar k = 0; k < COS_TERMS; k++) begin : g_cos
      localparam int          D     = COS_DIV[k];
      localparam int          SH    = 32 + $clog2(D);
      localparam logic [32:0] MAGIC = 33'(((longint'(1) << SH) + longint'(D) - 1) / longint'(D));
      logic [32:0] a_src;
      logic [64:0] mul;
      logic [64:0] quot;

      if (k == 0) begin : g_first
         assign a_src = Q32_ONE;
      end else begin : g_next
         assign a_src = ca_ff[k-1];
      end

      assign mul  = 65'(t2_p[2*k]) * 65'(a_src);
      assign quot = 65'(cx_ff[k]) * 65'(MAGIC);

      always_ff @(posedge clock) begin
         if (en) begin
            cx_ff[k] <= mul[63:32];
            ca_ff[k] <= Q32_ONE - 33'(quot >> SH);
         end
      end
   end

   // The sine lane starts one stage later so both lanes finish together.
   for (genvar k = 0; k < SIN_TERMS; k++) begin : g_sin
      localparam int          D     = SIN_DIV[k];
      localparam int          SH    = 32 + $clog2(D);
      localparam logic [32:0] MAGIC = 33'(((longint'(1) << SH) + longint'(D) - 1) / longint'(D));
      logic [32:0] a_src;
      logic [64:0] mul;
      logic [64:0] quot;

      if (k == 0) begin : g_first
         assign a_src = Q32_ONE;
      end else begin : g_next
         assign a_src = sa_ff[k-1];
      end

      assign mul  = 65'(t2_p[2*k+1]) * 65'(a_src);
      assign quot = 65'(sx_ff[k]) * 65'(MAGIC);

      always_ff @(posedge clock) begin
         if (en) begin
            sx_ff[k] <= mul[63:32];
            sa_ff[k] <= Q32_ONE - 33'(quot >> SH);
         end
      end
   end

   assign s_prod = 65'(t_p[2*COS_TERMS-1]) * 65'(sa_ff[SIN_TERMS-1]);

   always_ff @(posedge clock) begin
      if (en) begin
         s_ff <= s_prod[63:32];
      end
   end

   // A folded octant swaps sine and cosine; odd quadrants swap them once more.
   assign swap = meta_p[POS-1].fold ^ meta_p[POS-1].quad[0];

   always_ff @(posedge clock) begin
      if (en) begin
         trig_ff.cos_mag <= swap ? {1'b0, s_ff} : ca_ff[COS_TERMS-1];
         trig_ff.sin_mag <= swap ? ca_ff[COS_TERMS-1] : {1'b0, s_ff};
         trig_ff.cos_neg <= meta_p[POS-1].quad[1] ^ meta_p[POS-1].quad[0];
         trig_ff.sin_neg <= meta_p[POS-1].quad[1];
      end
   end

   assign trig_out = trig_ff;

endmodule

>>> rtl/box_muller_gaussian_unit.sv
// Box-Muller Gaussian pair generator: two uniform fractions in, two normal samples out.
//
//   channel   dir   payload                                handshake
//   req_if    in    uniform_radius, uniform_angle          valid / ready
//   rsp_if    out   normal_cos, normal_sin (signed Q3.F)   valid / ready
//
// One pair is taken every cycle unless a result waits at the output; results leave in the order taken.
// The latency is set by the 30 squaring stages of the logarithm and the 32 root stages.
// Reset clears only the valid bits of the pipeline; data registers are left as they are.
// While a result waits at the output, the whole pipeline holds and no input is taken.
module box_muller_gaussian_unit import bmg_pkg::*; #(
   parameter int UNIFORM_BITS  = UNIFORM_BITS_DEF,
   parameter int OUT_FRAC_BITS = OUT_FRAC_BITS_DEF
) (
   input logic       clock,
   input logic       reset,
   bmg_req_if.sink   req_if,
   bmg_rsp_if.source rsp_if
);
   localparam int OUT_W     = OUT_FRAC_BITS + 4;
   localparam int RSH       = 60 - OUT_FRAC_BITS;
   localparam int RW        = 65 - RSH;
   localparam int DLY       = NEGLOG_LAT + SQRT_LAT - TRIG_LAT;
   localparam int TOTAL_LAT = NEGLOG_LAT + SQRT_LAT + 2;

   logic                 en;
   logic [TOTAL_LAT-1:0] vld_ff;
   logic [TOTAL_LAT-1:0] vld_in;
   logic [63:0]          v_op;
   logic [ROOT_BITS-1:0] radius;
   trig_type             trig;
   trig_type             trig_d [DLY];
   logic [63:0]          prod_cos_ff;
   logic [63:0]          prod_sin_ff;
   logic                 neg_cos_ff;
   logic                 neg_sin_ff;
   logic [OUT_W-1:0]     norm_cos_ff;
   logic [OUT_W-1:0]     norm_sin_ff;

   // Round half up, saturate to the output range, then apply the sign.
   function automatic logic [OUT_W-1:0] scale_out(input logic [63:0] prod, input logic neg);
      logic [64:0]   sum;
      logic [RW-1:0] mag;
      logic [RW-1:0] lim;
      sum = {1'b0, prod} + (65'd1 << (RSH - 1));
      mag = sum[64:RSH];
      lim = RW'(1) << (OUT_FRAC_BITS + 3);
      if (neg) begin
         if (mag > lim) mag = lim;
         scale_out = OUT_W'(~mag + RW'(1));
      end else begin
         if (mag > lim - RW'(1)) mag = lim - RW'(1);
         scale_out = OUT_W'(mag);
      end
   endfunction

   assign en           = ~vld_ff[TOTAL_LAT-1] | rsp_if.ready;
   assign req_if.ready = en & ~reset;

   assign vld_in = {vld_ff[TOTAL_LAT-2:0], req_if.valid & req_if.ready};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= vld_in;
      end
   end

   bmg_neglog #(
      .UNIFORM_BITS (UNIFORM_BITS)
   ) u_neglog (
      .clock (clock),
      .en    (en),
      .x_in  (req_if.uniform_radius),
      .v_out (v_op)
   );

   bmg_sqrt u_sqrt (
      .clock    (clock),
      .en       (en),
      .v_in     (v_op),
      .root_out (radius)
   );

   bmg_sincos #(
      .UNIFORM_BITS (UNIFORM_BITS)
   ) u_sincos (
      .clock    (clock),
      .en       (en),
      .angle_in (req_if.uniform_angle),
      .trig_out (trig)
   );

   // The trig results wait here until the radius of the same item is ready.
   for (genvar j = 0; j < DLY; j++) begin : g_trig_dly
      always_ff @(posedge clock) begin
         if (en) begin
            trig_d[j] <= (j == 0) ? trig : trig_d[(j == 0) ? 0 : j - 1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         prod_cos_ff <= 64'(radius) * 64'(trig_d[DLY-1].cos_mag);
         prod_sin_ff <= 64'(radius) * 64'(trig_d[DLY-1].sin_mag);
         neg_cos_ff  <= trig_d[DLY-1].cos_neg;
         neg_sin_ff  <= trig_d[DLY-1].sin_neg;
         norm_cos_ff <= scale_out(prod_cos_ff, neg_cos_ff);
         norm_sin_ff <= scale_out(prod_sin_ff, neg_sin_ff);
      end
   end

   assign rsp_if.valid      = vld_ff[TOTAL_LAT-1];
   assign rsp_if.normal_cos = norm_cos_ff;
   assign rsp_if.normal_sin = norm_sin_ff;

   a_ready_when_drained: assert property (@(posedge clock) disable iff (reset)
      rsp_if.ready |-> req_if.ready)
      else $error("input not ready although the output is being drained");

   a_stall_holds_pipe: assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && !rsp_if.ready) |=> $stable(vld_ff))
      else $error("pipeline valid bits moved during an output stall");

   a_transfer_enters: assert property (@(posedge clock) disable iff (reset)
      (req_if.valid && req_if.ready) |=> vld_ff[0])
      else $error("accepted transfer did not enter the pipeline");

endmodule

>>> tb/sv/tb_top.sv
// Testbench for the Box-Muller Gaussian unit: random and directed pairs against a predictor.
module tb_top import bmg_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int UB = UNIFORM_BITS_DEF;
   localparam int FB = OUT_FRAC_BITS_DEF;
   localparam int OW = FB + 4;
   localparam longint unsigned LIMIT_CYCLES = 400000;

   typedef struct packed {
      logic [UB-1:0] radius_u;
      logic [UB-1:0] angle_u;
   } uniform_pair_type;

   typedef struct packed {
      logic signed [OW-1:0] z_cos;
      logic signed [OW-1:0] z_sin;
   } normal_pair_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   bmg_req_if #(.UNIFORM_BITS(UB)) req_if ();
   bmg_rsp_if #(.OUT_FRAC_BITS(FB)) rsp_if ();

   box_muller_gaussian_unit #(.UNIFORM_BITS(UB), .OUT_FRAC_BITS(FB)) i_dut (
      .clock(clock), .reset(reset), .req_if(req_if.sink), .rsp_if(rsp_if.source)
   );

   always #5 clock = ~clock;

   uniform_pair_type pending_pairs[$];
   normal_pair_type  expected_normals[$];
   int            idle_pct = 0;
   int            stall_pct = 0;
   int            errors = 0;
   int            sent = 0;
   int            received = 0;
   longint unsigned cycle_count = 0;

   function automatic longint unsigned int_sqrt(longint unsigned v);
      longint unsigned res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv >>= 2;
      while (bitv != 0) begin
         if (v >= res + bitv) begin
            v -= res + bitv;
            res = (res >> 1) + bitv;
         end else begin
            res >>= 1;
         end
         bitv >>= 2;
      end
      return res;
   endfunction

   function automatic longint unsigned gauss_radius(longint unsigned x);
      int p;
      longint unsigned m, frac, lq, w;
      p = 63;
      frac = 0;
      while (p > 0 && x[p] == 1'b0) p--;
      m = (p >= 31) ? (x >> (p - 31)) : (x << (31 - p));
      for (int i = 0; i < 30; i++) begin
         m = (m * m) >> 31;
         frac <<= 1;
         if (m >= 64'h1_0000_0000) begin
            frac |= 1;
            m >>= 1;
         end
      end
      lq = (longint'(UB - p) << 30) - frac;
      w = (lq * 64'd186065279) >> 27;
      return int_sqrt(w << 26);
   endfunction

   function automatic logic [OW-1:0] scaled_sample(longint unsigned radius,
                                                    longint unsigned mag, bit neg);
      longint unsigned prod, lim, r;
      prod = radius * mag;
      lim = 64'd1 << (FB + 3);
      r = (prod + (64'd1 << (59 - FB))) >> (60 - FB);
      if (neg) begin
         if (r > lim) r = lim;
         return OW'(~r + 1);
      end
      if (r > lim - 1) r = lim - 1;
      return OW'(r);
   endfunction

   function automatic normal_pair_type predict_normals(uniform_pair_type in_pair);
      longint unsigned x, a, r, rr, t, t2, sa, cb, s0, c0, sv, cv, radius, tmp;
      longint unsigned sdiv[5], cdiv[6];
      bit sneg, cneg;
      normal_pair_type res;
      sdiv = '{110, 72, 42, 20, 6};
      cdiv = '{132, 90, 56, 30, 12, 2};
      x = in_pair.radius_u;
      if (x == 0) x = 1;
      radius = gauss_radius(x);
      a = (UB >= 32) ? (longint'(in_pair.angle_u) >> (UB - 32))
                     : (longint'(in_pair.angle_u) << (32 - UB));
      a &= 64'hFFFF_FFFF;
      r = a & 64'h3FFF_FFFF;
      rr = (r < (64'd1 << 29)) ? r : ((64'd1 << 30) - r);
      t = (rr * 64'd3373259426) >> 29;
      t2 = (t * t) >> 32;
      sa = 64'h1_0000_0000;
      cb = 64'h1_0000_0000;
      for (int i = 0; i < 5; i++) sa = 64'h1_0000_0000 - (((t2 * sa) >> 32) / sdiv[i]);
      for (int i = 0; i < 6; i++) cb = 64'h1_0000_0000 - (((t2 * cb) >> 32) / cdiv[i]);
      s0 = (t * sa) >> 32;
      c0 = cb;
      if (r >= (64'd1 << 29)) begin
         tmp = s0;
         s0 = c0;
         c0 = tmp;
      end
      case (a[31:30])
         2'd0: begin cv = c0; cneg = 0; sv = s0; sneg = 0; end
         2'd1: begin cv = s0; cneg = 1; sv = c0; sneg = 0; end
         2'd2: begin cv = c0; cneg = 1; sv = s0; sneg = 1; end
         default: begin cv = s0; cneg = 0; sv = c0; sneg = 1; end
      endcase
      res.z_cos = scaled_sample(radius, cv, cneg);
      res.z_sin = scaled_sample(radius, sv, sneg);
      return res;
   endfunction

   // Driver: a new pair is presented only when the previous one has transferred.
   always @(posedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
         req_if.uniform_radius <= '0;
         req_if.uniform_angle <= '0;
      end else if (!req_if.valid || req_if.ready) begin
         if (req_if.valid) begin
            expected_normals.push_back(predict_normals({req_if.uniform_radius,
                                                        req_if.uniform_angle}));
            sent++;
         end
         if (pending_pairs.size() > 0 && $urandom_range(99) >= idle_pct) begin
            req_if.uniform_radius <= pending_pairs[0].radius_u;
            req_if.uniform_angle <= pending_pairs[0].angle_u;
            void'(pending_pairs.pop_front());
            req_if.valid <= 1'b1;
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   // Monitor: compare each transfer out with the oldest prediction.
   always @(posedge clock) begin
      normal_pair_type want;
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            received++;
            if (expected_normals.size() == 0) begin
               $display("%0t: unexpected result cos=%0d sin=%0d", $time,
                        rsp_if.normal_cos, rsp_if.normal_sin);
               errors++;
            end else begin
               want = expected_normals.pop_front();
               if (rsp_if.normal_cos !== want.z_cos) begin
                  $display("%0t: normal_cos expected %0d actual %0d", $time,
                           want.z_cos, rsp_if.normal_cos);
                  errors++;
               end
               if (rsp_if.normal_sin !== want.z_sin) begin
                  $display("%0t: normal_sin expected %0d actual %0d", $time,
                           want.z_sin, rsp_if.normal_sin);
                  errors++;
               end
            end
         end
         rsp_if.ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("FAIL");
         $finish;
      end
   end

   task automatic add_pair(logic [UB-1:0] ru, logic [UB-1:0] au);
      uniform_pair_type p;
      p.radius_u = ru;
      p.angle_u = au;
      pending_pairs.push_back(p);
   endtask

   // Checked at the falling edge so the driver's updates of the rising edge have settled.
   task automatic drain_queue();
      while (pending_pairs.size() > 0 || req_if.valid) @(negedge clock);
   endtask

   initial begin
      logic [UB-1:0] edge_vals[8];
      int shift;
      req_if.valid = 1'b0;
      req_if.uniform_radius = '0;
      req_if.uniform_angle = '0;
      rsp_if.ready = 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Extremes: zero radius input, all ones, single bits, and every octant boundary.
      edge_vals = '{32'h0, 32'h1, 32'hFFFF_FFFF, 32'h8000_0000,
                     32'h4000_0000, 32'h2000_0000, 32'hC000_0000, 32'h6000_0000};
      foreach (edge_vals[i]) add_pair(edge_vals[i], edge_vals[(i + 3) % 8]);
      foreach (edge_vals[i]) add_pair(edge_vals[(i * 5 + 2) % 8], edge_vals[i]);
      add_pair(32'h0, 32'hE000_0000);
      add_pair(32'h1234_5678, 32'hA000_0000);
      add_pair(32'hFFFF_FFFF, 32'h1FFF_FFFF);
      add_pair(32'h0000_0002, 32'h7FFF_FFFF);

      for (int phase = 0; phase < 4; phase++) begin
         idle_pct = (phase == 1 || phase == 3) ? ((phase == 3) ? 27 : 83) : 0;
         stall_pct = (phase == 2 || phase == 3) ? ((phase == 3) ? 27 : 83) : 0;
         for (int n = 0; n < 200; n++) begin
            // Vary the magnitude so small u1 (large radius) is well covered.
            shift = $urandom_range(3) == 0 ? $urandom_range(31) : 0;
            add_pair($urandom() >> shift, $urandom());
            // Short bursts without gaps between idle stretches.
            if (n % 50 == 25) drain_queue();
         end
         drain_queue();
      end

      while (expected_normals.size() > 0) @(posedge clock);
      repeat (100) @(posedge clock);
      $display("Sent %0d uniform pairs over four idle/stall phases, %0d results checked.",
               sent, received);
      if (errors == 0 && expected_normals.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end
endmodule
